// File: sv/load_based_power_mode_governor_assert.svh
// Assertion helpers shared by the governor RTL.
`ifndef LOAD_BASED_POWER_MODE_GOVERNOR_ASSERT_SVH
`define LOAD_BASED_POWER_MODE_GOVERNOR_ASSERT_SVH

// Same-cycle implication, held off during reset.
`define LBPMG_ASSERT_IMPL(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (pre) |-> (post)) \
        else $error("governor check failed: same-cycle implication");

// Next-cycle implication, held off during reset.
`define LBPMG_ASSERT_NEXT(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (pre) |=> (post)) \
        else $error("governor check failed: next-cycle implication");

`endif

// File: sv/lbpmg_pkg.sv
package lbpmg_pkg;

    localparam int NUM_CPUS      = 2;
    localparam int HISTORY_DEPTH = 4;
    localparam int FRAC_BITS     = 11;

    localparam int PCT           = 100;
    localparam int BAL_FALLBACK  = 50;
    localparam int MS_PER_SEC    = 1000;

    localparam int LOAD_W     = 7;
    localparam int CPU_IDX_W  = (NUM_CPUS > 1) ? $clog2(NUM_CPUS) : 1;
    localparam int HIST_IDX_W = $clog2(HISTORY_DEPTH);
    localparam int TOTAL_W    = $clog2(NUM_CPUS * PCT + 1);
    localparam int HSUM_W     = $clog2(HISTORY_DEPTH * PCT + 1);
    localparam int CNT_W      = $clog2(NUM_CPUS + 1);

    // input field widths and tdata offsets
    localparam int DELTA_W     = 32;
    localparam int LF_W        = 22;
    localparam int IRQ_W       = 32;
    localparam int MS_W        = 16;
    localparam int CPU_FIELD_W = 1 + 2 * DELTA_W;
    localparam int OFS_GLB     = NUM_CPUS * CPU_FIELD_W;
    localparam int OFS_LF      = OFS_GLB;
    localparam int OFS_IRQ     = OFS_LF + LF_W;
    localparam int OFS_MS      = OFS_IRQ + IRQ_W;
    localparam int OFS_UCHG    = OFS_MS + MS_W;
    localparam int S_TDATA_W   = ((OFS_UCHG + 1 + 7) / 8) * 8;

    // result field widths
    localparam int OUT_TOT_W = 8;
    localparam int BAL_W     = 15;
    localparam int AVG_W     = 18;
    localparam int AVG_CALC_W = LF_W + 8;
    localparam int RES_W     = 2 + 1 + 2 + 2 * OUT_TOT_W + BAL_W + AVG_W + IRQ_W;
    localparam int M_TDATA_W = ((RES_W + 7) / 8) * 8;

    // shared divider
    localparam int DIV_NUM_W  = 40;
    localparam int DIV_DEN_W  = 32;
    localparam int DIV_Q_W    = 32;
    localparam int DIV_CNT_W  = 6;
    localparam int LOAD_QBITS = LOAD_W;
    localparam int SECS_QBITS = 7;
    localparam int RATE_QBITS = 32;
    localparam int BAL_QBITS  = $clog2(PCT * NUM_CPUS * PCT + 1);

    // configuration port
    localparam int PADDR_W = 5;
    localparam int PDATA_W = 32;
    localparam int CFG_IDX_W = 3;

    localparam int ME_AUTO  = 0;
    localparam int ME_USER  = 1;
    localparam int ME_FORCE = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_AVG_LOW     = 3'd0,
        REG_AVG_HIGH    = 3'd1,
        REG_UNBAL       = 3'd2,
        REG_TREND_UNBAL = 3'd3,
        REG_IDLE_TREND  = 3'd4,
        REG_INSTANT     = 3'd5,
        REG_IRQ_RATE    = 3'd6,
        REG_MODE_EN     = 3'd7
    } cfg_reg_t;

    typedef enum logic [1:0] {
        MODE_NORMAL = 2'd0,
        MODE_AUTO   = 2'd1,
        MODE_USER   = 2'd2,
        MODE_NONE   = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        DEC_NONE  = 2'd0,
        DEC_RAISE = 2'd1,
        DEC_LOWER = 2'd2
    } decision_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LOAD,
        ST_LOAD_WAIT,
        ST_TREND,
        ST_BAL,
        ST_BAL_WAIT,
        ST_SECS,
        ST_SECS_WAIT,
        ST_RATE,
        ST_RATE_WAIT,
        ST_DECIDE
    } state_t;

    typedef struct packed {
        logic                 start;
        logic [DIV_NUM_W-1:0] num;
        logic [DIV_DEN_W-1:0] den;
        logic [DIV_CNT_W-1:0] qbits;
    } div_req_t;

    typedef struct packed {
        logic               busy;
        logic               done;
        logic [DIV_Q_W-1:0] quo;
    } div_rsp_t;

    // first member lands in the top bits, so chosen_mode sits at bit 0
    typedef struct packed {
        logic [M_TDATA_W-RES_W-1:0] pad;
        logic [IRQ_W-1:0]           irq_rate;
        logic [AVG_W-1:0]           avg_hundredths;
        logic [BAL_W-1:0]           balance_ratio;
        logic [OUT_TOT_W-1:0]       trend_total;
        logic [OUT_TOT_W-1:0]       instant_total;
        decision_t                  decision;
        logic                       apply_change;
        mode_t                      chosen_mode;
    } result_t;

endpackage

// File: sv/lbpmg_div.sv
// Restoring divider, one quotient bit per cycle. The caller sets qbits so
// that the quotient fits in qbits bits; the top of the dividend then
// starts out below the divisor.
module lbpmg_div
    import lbpmg_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  div_req_t req,
    output div_rsp_t rsp
);

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic [DIV_DEN_W-1:0] rem_reg, rem_next;
    logic [DIV_DEN_W-1:0] den_reg, den_next;
    logic [DIV_NUM_W-1:0] low_reg, low_next;
    logic [DIV_Q_W-1:0]   quo_reg, quo_next;

    logic [DIV_DEN_W:0]   shifted;
    logic [DIV_DEN_W+1:0] trial;
    logic                 fits;

    assign shifted = {rem_reg, low_reg[DIV_NUM_W-1]};
    assign trial   = {1'b0, shifted} - {2'b00, den_reg};
    assign fits    = !trial[DIV_DEN_W+1];

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        low_next  = low_reg;
        quo_next  = quo_reg;
        if (req.start) begin
            rem_next  = DIV_DEN_W'(req.num >> req.qbits);
            low_next  = req.num << (DIV_CNT_W'(DIV_NUM_W) - req.qbits);
            den_next  = req.den;
            quo_next  = '0;
            cnt_next  = req.qbits;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            rem_next = fits ? trial[DIV_DEN_W-1:0] : shifted[DIV_DEN_W-1:0];
            quo_next = {quo_reg[DIV_Q_W-2:0], fits};
            low_next = low_reg << 1;
            cnt_next = cnt_reg - DIV_CNT_W'(1);
            if (cnt_reg == DIV_CNT_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg <= rem_next;
        den_reg <= den_next;
        low_reg <= low_next;
        quo_reg <= quo_next;
    end

    assign rsp.busy = busy_reg;
    assign rsp.done = done_reg;
    assign rsp.quo  = quo_reg;

endmodule

// File: sv/load_based_power_mode_governor.sv
// Load-based power mode governor: one input item per sampling tick.
// s_ channel: per-CPU online flag with wall/idle deltas, load average,
// interrupt delta, elapsed milliseconds and a user-settings flag.
// m_ channel: chosen mode, apply flag, raise/lower decision and the load
// figures behind it. APB port holds the thresholds and mode enables.
// One shared restoring divider (one quotient bit per cycle) does the long
// division: per-CPU load percent (7 bits each), balance ratio (15 bits),
// seconds from milliseconds (7 bits) and interrupt rate (32 bits).
// How long an item takes from accept to the registered result depends on
// the divisions it needs, from none (nothing to divide) to all of them (both
// CPUs valid, balance and rate divided); s_tready is high only while the sequencer idles.
// The result sits in an output register, so the next item is taken while
// it waits; a stalled m_tready holds the sequencer at its final step until
// the output register frees up.
// Reset: configuration registers return to their defaults, every history slot reads 100,
// current mode is "none", and the first item after reset reports a zero
// interrupt rate.
module load_based_power_mode_governor
    import lbpmg_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    // s_tdata, low bit up: cpu0_online, cpu0_wall_delta, cpu0_idle_delta,
    // cpu1_online, cpu1_wall_delta, cpu1_idle_delta, load_fixed, irq_delta,
    // elapsed_ms, user_changed, zero pad
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,
    // m_tdata, low bit up: chosen_mode, apply_change, decision,
    // instant_total, trend_total, balance_ratio, avg_hundredths, irq_rate,
    // zero pad
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [PADDR_W-1:0]   paddr,
    input  logic [PDATA_W-1:0]   pwdata,
    output logic [PDATA_W-1:0]   prdata,
    output logic                 pready
);

    // ---------------- configuration registers ----------------
    logic [AVG_W-1:0] avg_low_reg, avg_high_reg;
    logic [15:0]      unbal_reg;
    logic [7:0]       trend_unbal_reg, idle_trend_reg, instant_lim_reg;
    logic [IRQ_W-1:0] irq_lim_reg;
    logic [2:0]       mode_en_reg;
    cfg_reg_t         cfg_idx;
    logic             cfg_we;

    assign pready  = 1'b1;
    assign cfg_idx = cfg_reg_t'(paddr[PADDR_W-1:2]);
    assign cfg_we  = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            avg_low_reg     <= AVG_W'(175);
            avg_high_reg    <= AVG_W'(450);
            unbal_reg       <= 16'd210;
            trend_unbal_reg <= 8'd40;
            idle_trend_reg  <= 8'd5;
            instant_lim_reg <= 8'd85;
            irq_lim_reg     <= IRQ_W'(1000);
            mode_en_reg     <= 3'd0;
        end else if (cfg_we) begin
            case (cfg_idx)
                REG_AVG_LOW:     avg_low_reg     <= pwdata[AVG_W-1:0];
                REG_AVG_HIGH:    avg_high_reg    <= pwdata[AVG_W-1:0];
                REG_UNBAL:       unbal_reg       <= pwdata[15:0];
                REG_TREND_UNBAL: trend_unbal_reg <= pwdata[7:0];
                REG_IDLE_TREND:  idle_trend_reg  <= pwdata[7:0];
                REG_INSTANT:     instant_lim_reg <= pwdata[7:0];
                REG_IRQ_RATE:    irq_lim_reg     <= pwdata[IRQ_W-1:0];
                REG_MODE_EN:     mode_en_reg     <= pwdata[2:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (cfg_idx)
            REG_AVG_LOW:     prdata = PDATA_W'(avg_low_reg);
            REG_AVG_HIGH:    prdata = PDATA_W'(avg_high_reg);
            REG_UNBAL:       prdata = PDATA_W'(unbal_reg);
            REG_TREND_UNBAL: prdata = PDATA_W'(trend_unbal_reg);
            REG_IDLE_TREND:  prdata = PDATA_W'(idle_trend_reg);
            REG_INSTANT:     prdata = PDATA_W'(instant_lim_reg);
            REG_IRQ_RATE:    prdata = irq_lim_reg;
            REG_MODE_EN:     prdata = PDATA_W'(mode_en_reg);
            default:         prdata = '0;
        endcase
    end

    // ---------------- captured item ----------------
    logic                online_reg [NUM_CPUS];
    logic [DELTA_W-1:0]  wall_reg   [NUM_CPUS];
    logic [DELTA_W-1:0]  idle_reg   [NUM_CPUS];
    logic [LF_W-1:0]     lf_reg;
    logic [IRQ_W-1:0]    irqd_reg;
    logic [MS_W-1:0]     ems_reg;
    logic                uchg_reg;
    logic                s_accept;

    assign s_accept = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            for (int c = 0; c < NUM_CPUS; c++) begin
                online_reg[c] <= s_tdata[c*CPU_FIELD_W];
                wall_reg[c]   <= s_tdata[c*CPU_FIELD_W+1 +: DELTA_W];
                idle_reg[c]   <= s_tdata[c*CPU_FIELD_W+1+DELTA_W +: DELTA_W];
            end
            lf_reg   <= s_tdata[OFS_LF +: LF_W];
            irqd_reg <= s_tdata[OFS_IRQ +: IRQ_W];
            ems_reg  <= s_tdata[OFS_MS +: MS_W];
            uchg_reg <= s_tdata[OFS_UCHG];
        end
    end

    // ---------------- state ----------------
    state_t                state_reg, state_next;
    logic [CPU_IDX_W-1:0]  cpu_idx_reg, cpu_idx_next;
    logic [TOTAL_W-1:0]    instant_reg, instant_next;
    logic [TOTAL_W-1:0]    trend_reg, trend_next;
    logic [LOAD_W-1:0]     min_reg, min_next;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    logic                  any_reg, any_next;
    logic [BAL_W-1:0]      bal_reg, bal_next;
    logic [AVG_W-1:0]      avg_reg, avg_next;
    logic [SECS_QBITS-1:0] secs_reg, secs_next;
    logic [IRQ_W-1:0]      rate_reg, rate_next;
    mode_t                 cur_mode_reg, cur_mode_next;
    logic                  seen_reg, seen_next;
    logic                  pend_reg, pend_next;
    logic                  m_valid_reg, m_valid_next;
    result_t               res_reg, res_next;

    logic [LOAD_W-1:0]     hist_reg [NUM_CPUS][HISTORY_DEPTH];
    logic [HIST_IDX_W-1:0] slot_reg [NUM_CPUS];
    logic                  hist_we;

    div_req_t div_req;
    div_rsp_t div_rsp;

    lbpmg_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    // current CPU sample
    logic               cur_ok, last_cpu, out_free, commit;
    logic [DELTA_W-1:0] cur_wall, cur_idle;

    assign cur_wall = wall_reg[cpu_idx_reg];
    assign cur_idle = idle_reg[cpu_idx_reg];
    assign cur_ok   = online_reg[cpu_idx_reg] && (cur_wall != '0) && (cur_wall >= cur_idle);
    assign last_cpu = (cpu_idx_reg == CPU_IDX_W'(NUM_CPUS - 1));
    assign out_free = !m_valid_reg || m_tready;
    assign commit   = (state_reg == ST_DECIDE) && out_free;
    assign s_tready = (state_reg == ST_IDLE);

    // ring averages; order inside the ring does not matter for the sum
    logic [HSUM_W-1:0] ring_sum [NUM_CPUS];
    logic [LOAD_W-1:0] ring_avg [NUM_CPUS];
    logic [TOTAL_W-1:0] trend_calc;
    logic [LOAD_W-1:0]  min_calc;
    logic [CNT_W-1:0]   cnt_calc;
    logic               any_calc;

    always_comb begin
        for (int c = 0; c < NUM_CPUS; c++) begin
            ring_sum[c] = '0;
            for (int k = 0; k < HISTORY_DEPTH; k++) begin
                ring_sum[c] = ring_sum[c] + HSUM_W'(hist_reg[c][k]);
            end
            ring_avg[c] = LOAD_W'(ring_sum[c] / HISTORY_DEPTH);
        end
    end

    always_comb begin
        trend_calc = '0;
        min_calc   = '0;
        cnt_calc   = '0;
        any_calc   = 1'b0;
        for (int c = 0; c < NUM_CPUS; c++) begin
            if (online_reg[c]) begin
                trend_calc = trend_calc + TOTAL_W'(ring_avg[c]);
                if (!any_calc || ring_avg[c] < min_calc) begin
                    min_calc = ring_avg[c];
                end
                any_calc = 1'b1;
                cnt_calc = cnt_calc + CNT_W'(1);
            end
        end
    end

    // load average in hundredths
    logic [AVG_CALC_W-1:0] avg_int, avg_frac, avg_calc;

    assign avg_int  = AVG_CALC_W'(lf_reg >> FRAC_BITS) * AVG_CALC_W'(PCT);
    assign avg_frac = (AVG_CALC_W'(lf_reg[FRAC_BITS-1:0]) * AVG_CALC_W'(PCT)) >> FRAC_BITS;
    assign avg_calc = avg_int + avg_frac;

    // decision cascade
    logic      auto_en, user_en, user_forced, pend_eff, inc, dec, apply;
    mode_t     chosen;
    decision_t decision;

    assign auto_en     = mode_en_reg[ME_AUTO];
    assign user_en     = mode_en_reg[ME_USER];
    assign user_forced = user_en && mode_en_reg[ME_FORCE];
    assign pend_eff    = pend_reg || uchg_reg;

    always_comb begin
        inc = 1'b0;
        dec = 1'b0;
        if (instant_reg > instant_lim_reg || rate_reg > irq_lim_reg) begin
            inc = 1'b1;
        end else if (!user_en && auto_en) begin
            if (avg_reg > avg_high_reg) begin
                inc = 1'b1;
            end else if (trend_reg < idle_trend_reg) begin
                dec = 1'b1;
            end else if (bal_reg > unbal_reg && trend_reg < trend_unbal_reg) begin
                dec = 1'b1;
            end else if (avg_reg < avg_low_reg) begin
                dec = 1'b1;
            end else if (pend_eff) begin
                dec = 1'b1;
            end
        end else begin
            dec = 1'b1;
        end

        chosen = MODE_NONE;
        if (dec) begin
            if (user_en) begin
                chosen = MODE_USER;
            end else if (auto_en) begin
                chosen = MODE_AUTO;
            end
        end else if (inc && !user_forced) begin
            chosen = MODE_NORMAL;
        end

        apply = (chosen != MODE_NONE) &&
                ((chosen != cur_mode_reg) || (pend_eff && chosen == MODE_USER));

        if (dec) begin
            decision = DEC_LOWER;
        end else if (inc) begin
            decision = DEC_RAISE;
        end else begin
            decision = DEC_NONE;
        end
    end

    // sequencer: next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_accept) state_next = ST_LOAD;
            end
            ST_LOAD: begin
                if (cur_ok) state_next = ST_LOAD_WAIT;
                else if (last_cpu) state_next = ST_TREND;
            end
            ST_LOAD_WAIT: begin
                if (div_rsp.done) state_next = last_cpu ? ST_TREND : ST_LOAD;
            end
            ST_TREND: state_next = ST_BAL;
            ST_BAL: begin
                if (any_reg && min_reg > idle_trend_reg) state_next = ST_BAL_WAIT;
                else state_next = ST_SECS;
            end
            ST_BAL_WAIT: begin
                if (div_rsp.done) state_next = ST_SECS;
            end
            ST_SECS: begin
                state_next = seen_reg ? ST_SECS_WAIT : ST_DECIDE;
            end
            ST_SECS_WAIT: begin
                if (div_rsp.done) state_next = ST_RATE;
            end
            ST_RATE: begin
                state_next = (secs_reg != '0) ? ST_RATE_WAIT : ST_DECIDE;
            end
            ST_RATE_WAIT: begin
                if (div_rsp.done) state_next = ST_DECIDE;
            end
            ST_DECIDE: begin
                if (out_free) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // sequencer: datapath and divider requests
    always_comb begin
        cpu_idx_next  = cpu_idx_reg;
        instant_next  = instant_reg;
        trend_next    = trend_reg;
        min_next      = min_reg;
        cnt_next      = cnt_reg;
        any_next      = any_reg;
        bal_next      = bal_reg;
        avg_next      = avg_reg;
        secs_next     = secs_reg;
        rate_next     = rate_reg;
        cur_mode_next = cur_mode_reg;
        seen_next     = seen_reg;
        pend_next     = pend_reg;
        res_next      = res_reg;
        m_valid_next  = m_valid_reg && !m_tready;
        hist_we       = 1'b0;
        div_req       = '0;
        case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    cpu_idx_next = '0;
                    instant_next = '0;
                end
            end
            ST_LOAD: begin
                if (cur_ok) begin
                    div_req.start = 1'b1;
                    div_req.num   = DIV_NUM_W'(cur_wall - cur_idle) * DIV_NUM_W'(PCT);
                    div_req.den   = DIV_DEN_W'(cur_wall);
                    div_req.qbits = DIV_CNT_W'(LOAD_QBITS);
                end else if (!last_cpu) begin
                    cpu_idx_next = cpu_idx_reg + CPU_IDX_W'(1);
                end
            end
            ST_LOAD_WAIT: begin
                if (div_rsp.done) begin
                    hist_we      = 1'b1;
                    instant_next = instant_reg + TOTAL_W'(div_rsp.quo[LOAD_W-1:0]);
                    if (!last_cpu) cpu_idx_next = cpu_idx_reg + CPU_IDX_W'(1);
                end
            end
            ST_TREND: begin
                trend_next = trend_calc;
                min_next   = min_calc;
                cnt_next   = cnt_calc;
                any_next   = any_calc;
                avg_next   = AVG_W'(avg_calc);
            end
            ST_BAL: begin
                if (any_reg && min_reg > idle_trend_reg) begin
                    div_req.start = 1'b1;
                    div_req.num   = DIV_NUM_W'(trend_reg) * DIV_NUM_W'(PCT);
                    div_req.den   = DIV_DEN_W'(min_reg);
                    div_req.qbits = DIV_CNT_W'(BAL_QBITS);
                end else if (any_reg) begin
                    bal_next = BAL_W'(BAL_FALLBACK << cnt_reg);
                end else begin
                    bal_next = '0;
                end
            end
            ST_BAL_WAIT: begin
                if (div_rsp.done) bal_next = div_rsp.quo[BAL_W-1:0];
            end
            ST_SECS: begin
                if (seen_reg) begin
                    div_req.start = 1'b1;
                    div_req.num   = DIV_NUM_W'(ems_reg);
                    div_req.den   = DIV_DEN_W'(MS_PER_SEC);
                    div_req.qbits = DIV_CNT_W'(SECS_QBITS);
                end else begin
                    rate_next = '0;
                end
            end
            ST_SECS_WAIT: begin
                if (div_rsp.done) secs_next = div_rsp.quo[SECS_QBITS-1:0];
            end
            ST_RATE: begin
                if (secs_reg != '0) begin
                    div_req.start = 1'b1;
                    div_req.num   = DIV_NUM_W'(irqd_reg);
                    div_req.den   = DIV_DEN_W'(secs_reg);
                    div_req.qbits = DIV_CNT_W'(RATE_QBITS);
                end else begin
                    rate_next = '1;
                end
            end
            ST_RATE_WAIT: begin
                if (div_rsp.done) rate_next = div_rsp.quo[IRQ_W-1:0];
            end
            ST_DECIDE: begin
                if (out_free) begin
                    res_next.pad            = '0;
                    res_next.irq_rate       = rate_reg;
                    res_next.avg_hundredths = avg_reg;
                    res_next.balance_ratio  = bal_reg;
                    res_next.trend_total    = OUT_TOT_W'(trend_reg);
                    res_next.instant_total  = OUT_TOT_W'(instant_reg);
                    res_next.decision       = decision;
                    res_next.apply_change   = apply;
                    res_next.chosen_mode    = chosen;
                    m_valid_next            = 1'b1;
                    seen_next               = 1'b1;
                    pend_next               = (chosen != MODE_NONE) ? 1'b0 : pend_eff;
                    if (apply) cur_mode_next = chosen;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            cpu_idx_reg  <= '0;
            cur_mode_reg <= MODE_NONE;
            seen_reg     <= 1'b0;
            pend_reg     <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            cpu_idx_reg  <= cpu_idx_next;
            cur_mode_reg <= cur_mode_next;
            seen_reg     <= seen_next;
            pend_reg     <= pend_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        instant_reg <= instant_next;
        trend_reg   <= trend_next;
        min_reg     <= min_next;
        cnt_reg     <= cnt_next;
        any_reg     <= any_next;
        bal_reg     <= bal_next;
        avg_reg     <= avg_next;
        secs_reg    <= secs_next;
        rate_reg    <= rate_next;
        res_reg     <= res_next;
    end

    // per-CPU load rings
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int c = 0; c < NUM_CPUS; c++) begin
                slot_reg[c] <= '0;
                for (int k = 0; k < HISTORY_DEPTH; k++) begin
                    hist_reg[c][k] <= LOAD_W'(PCT);
                end
            end
        end else if (hist_we) begin
            hist_reg[cpu_idx_reg][slot_reg[cpu_idx_reg]] <= div_rsp.quo[LOAD_W-1:0];
            if (slot_reg[cpu_idx_reg] == HIST_IDX_W'(HISTORY_DEPTH - 1)) begin
                slot_reg[cpu_idx_reg] <= '0;
            end else begin
                slot_reg[cpu_idx_reg] <= slot_reg[cpu_idx_reg] + HIST_IDX_W'(1);
            end
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = res_reg;

    // ---------------- checks ----------------
`include "load_based_power_mode_governor_assert.svh"

    `LBPMG_ASSERT_IMPL(a_div_start_free, aclk, aresetn, div_req.start, !div_rsp.busy)
    `LBPMG_ASSERT_IMPL(a_accept_div_quiet, aclk, aresetn, s_accept, !div_rsp.busy && !div_rsp.done)
    `LBPMG_ASSERT_NEXT(a_pend_cleared, aclk, aresetn, commit && chosen != MODE_NONE, !pend_reg)
    `LBPMG_ASSERT_IMPL(a_apply_has_mode, aclk, aresetn, m_valid_reg && res_reg.apply_change, res_reg.chosen_mode != MODE_NONE)

endmodule

// File: sim/load_based_power_mode_governor_test.sv
module load_based_power_mode_governor_test;
    timeunit 1ns;
    timeprecision 1ps;
    import lbpmg_pkg::*;

    localparam int STALL_LIMIT  = 4000;
    localparam int NUM_PHASES   = 16;
    localparam int PHASE_TICKS  = 78;
    localparam int MAX_GAP      = 14;
    localparam int DRAIN_CYCLES = 100;

    typedef struct {
        logic [NUM_CPUS-1:0]              online;
        logic [NUM_CPUS-1:0][DELTA_W-1:0] wall;
        logic [NUM_CPUS-1:0][DELTA_W-1:0] idle;
        logic [LF_W-1:0]                  load_fixed;
        logic [IRQ_W-1:0]                 irq_delta;
        logic [MS_W-1:0]                  elapsed_ms;
        logic                             user_changed;
    } gov_tick_t;

    typedef struct {
        mode_t              mode;
        logic               apply;
        decision_t          dec;
        logic [OUT_TOT_W-1:0] instant;
        logic [OUT_TOT_W-1:0] trend;
        logic [BAL_W-1:0]   balance;
        logic [AVG_W-1:0]   avg;
        logic [IRQ_W-1:0]   irq_rate;
    } gov_result_t;

    typedef struct {
        gov_tick_t   tick;
        bit          known;
        gov_result_t want;
    } stim_row_t;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b1;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 psel = 1'b0;
    logic                 penable = 1'b0;
    logic                 pwrite = 1'b0;
    logic [PADDR_W-1:0]   paddr = '0;
    logic [PDATA_W-1:0]   pwdata = '0;
    logic [PDATA_W-1:0]   prdata;
    logic                 pready;

    // predictor copy of the registers
    logic [AVG_W-1:0]   cfg_avg_low;
    logic [AVG_W-1:0]   cfg_avg_high;
    logic [15:0]        cfg_unbal;
    logic [7:0]         cfg_trend_unbal;
    logic [7:0]         cfg_idle_trend;
    logic [7:0]         cfg_instant;
    logic [IRQ_W-1:0]   cfg_irq_rate;
    logic [2:0]         cfg_mode_en;

    // predictor copy of the block state
    logic [LOAD_W-1:0]     load_ring [NUM_CPUS][HISTORY_DEPTH];
    logic [HIST_IDX_W-1:0] ring_slot [NUM_CPUS];
    mode_t                 cur_mode;
    bit                    irq_seen;
    bit                    user_pend;

    gov_result_t expected_results[$];
    stim_row_t   stim_rows[$];
    gov_result_t blank_res;

    bit tx_no_gaps, rx_no_gaps;
    int rx_wait, quiet_cycles;
    int errors, ticks_sent, results_seen, phases_run;
    int n_raise, n_lower, n_hold, n_apply;

    load_based_power_mode_governor u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always #4 aclk = ~aclk;

    function automatic gov_result_t governor_predict(gov_tick_t t);
        gov_result_t r;
        logic [63:0] wall, idle, instant, trend, balance, avg, lf;
        logic [31:0] pct, min_load, secs, rate;
        logic [8:0]  ring_sum;
        int          online_cnt;
        bit          inc, dec, auto_en, user_en, forced;
        instant = 0;
        trend = 0;
        min_load = 0;
        online_cnt = 0;
        rate = 0;
        inc = 0;
        dec = 0;
        for (int c = 0; c < NUM_CPUS; c++) begin
            if (t.online[c]) begin
                wall = t.wall[c];
                idle = t.idle[c];
                if (wall != 0 && wall >= idle) begin
                    pct = (100 * (wall - idle)) / wall;
                    load_ring[c][ring_slot[c]] = pct[LOAD_W-1:0];
                    ring_slot[c] = (ring_slot[c] + 1) % HISTORY_DEPTH;
                    instant += pct;
                end
            end
        end
        for (int c = 0; c < NUM_CPUS; c++) begin
            if (t.online[c]) begin
                ring_sum = 0;
                for (int k = 0; k < HISTORY_DEPTH; k++)
                    ring_sum += load_ring[c][k];
                pct = ring_sum / HISTORY_DEPTH;
                trend += pct;
                if (online_cnt == 0 || pct < min_load)
                    min_load = pct;
                online_cnt++;
            end
        end
        if (online_cnt == 0)
            balance = 0;
        else if (min_load > cfg_idle_trend)
            balance = (100 * trend) / min_load;
        else
            balance = 64'd50 << online_cnt;

        lf = t.load_fixed;
        avg = (lf >> FRAC_BITS) * 100 +
              (((lf & ((64'd1 << FRAC_BITS) - 1)) * 100) >> FRAC_BITS) % 100;

        // first tick after reset has no baseline, rate stays zero
        if (irq_seen) begin
            secs = t.elapsed_ms / 1000;
            rate = (secs != 0) ? t.irq_delta / secs : 32'hFFFF_FFFF;
        end
        irq_seen = 1;
        if (t.user_changed)
            user_pend = 1;

        auto_en = cfg_mode_en[ME_AUTO];
        user_en = cfg_mode_en[ME_USER];
        forced  = user_en && cfg_mode_en[ME_FORCE];

        if (instant > cfg_instant || rate > cfg_irq_rate) begin
            inc = 1;
        end else if (!user_en && auto_en) begin
            if (avg > cfg_avg_high)
                inc = 1;
            else if (trend < cfg_idle_trend)
                dec = 1;
            else if (balance > cfg_unbal && trend < cfg_trend_unbal)
                dec = 1;
            else if (avg < cfg_avg_low)
                dec = 1;
            else if (user_pend)
                dec = 1;
        end else begin
            dec = 1;
        end

        r.mode = MODE_NONE;
        if (dec) begin
            if (user_en)
                r.mode = MODE_USER;
            else if (auto_en)
                r.mode = MODE_AUTO;
        end else if (inc && !forced) begin
            r.mode = MODE_NORMAL;
        end

        r.apply = 0;
        if (r.mode != MODE_NONE) begin
            r.apply = (r.mode != cur_mode) || (user_pend && r.mode == MODE_USER);
            if (r.apply)
                cur_mode = r.mode;
            user_pend = 0;
        end

        r.dec      = dec ? DEC_LOWER : (inc ? DEC_RAISE : DEC_NONE);
        r.instant  = instant[OUT_TOT_W-1:0];
        r.trend    = trend[OUT_TOT_W-1:0];
        r.balance  = balance[BAL_W-1:0];
        r.avg      = avg[AVG_W-1:0];
        r.irq_rate = rate;
        return r;
    endfunction

    function automatic logic [S_TDATA_W-1:0] pack_tick(gov_tick_t t);
        logic [S_TDATA_W-1:0] d;
        d = '0;
        for (int c = 0; c < NUM_CPUS; c++) begin
            d[c*CPU_FIELD_W]                     = t.online[c];
            d[c*CPU_FIELD_W + 1 +: DELTA_W]      = t.wall[c];
            d[c*CPU_FIELD_W + 1 + DELTA_W +: DELTA_W] = t.idle[c];
        end
        d[OFS_LF +: LF_W]   = t.load_fixed;
        d[OFS_IRQ +: IRQ_W] = t.irq_delta;
        d[OFS_MS +: MS_W]   = t.elapsed_ms;
        d[OFS_UCHG]         = t.user_changed;
        return d;
    endfunction

    function automatic gov_tick_t mk_tick(bit on0, logic [31:0] w0, logic [31:0] i0,
                                          bit on1, logic [31:0] w1, logic [31:0] i1,
                                          logic [LF_W-1:0] lf, logic [31:0] irq,
                                          logic [15:0] ms, bit uc);
        gov_tick_t t;
        t.online       = {on1, on0};
        t.wall[0]      = w0;
        t.idle[0]      = i0;
        t.wall[1]      = w1;
        t.idle[1]      = i1;
        t.load_fixed   = lf;
        t.irq_delta    = irq;
        t.elapsed_ms   = ms;
        t.user_changed = uc;
        return t;
    endfunction

    function automatic gov_result_t mk_res(mode_t m, bit ap, decision_t d, int inst,
                                           int trend, int bal, int avg, logic [31:0] irq);
        gov_result_t r;
        r.mode     = m;
        r.apply    = ap;
        r.dec      = d;
        r.instant  = inst;
        r.trend    = trend;
        r.balance  = bal;
        r.avg      = avg;
        r.irq_rate = irq;
        return r;
    endfunction

    function automatic void add_row(gov_tick_t t);
        stim_rows.push_back('{tick: t, known: 1'b0, want: blank_res});
    endfunction

    // mostly sane samples, some invalid and some raw random values
    function automatic gov_tick_t rand_tick();
        gov_tick_t t;
        int        kind;
        for (int c = 0; c < NUM_CPUS; c++) begin
            t.online[c] = ($urandom_range(0, 7) != 0);
            kind = $urandom_range(0, 9);
            case (kind)
                0: begin
                    t.wall[c] = 0;
                    t.idle[c] = $urandom;
                end
                1: begin
                    t.wall[c] = $urandom_range(1, 1000000);
                    t.idle[c] = t.wall[c] + $urandom_range(1, 1000);
                end
                2: begin
                    t.wall[c] = $urandom;
                    t.idle[c] = $urandom;
                end
                3, 4, 5: begin
                    // nearly idle CPU, drags the trend down
                    t.wall[c] = $urandom_range(1000, 2000000);
                    t.idle[c] = t.wall[c] - $urandom_range(0, t.wall[c] / 20);
                end
                default: begin
                    t.wall[c] = $urandom_range(1, 2000000);
                    t.idle[c] = $urandom_range(0, t.wall[c]);
                end
            endcase
        end
        t.load_fixed = ($urandom_range(0, 7) == 0) ? $urandom : $urandom_range(0, 16 << FRAC_BITS);
        t.irq_delta  = ($urandom_range(0, 7) == 0) ? $urandom : $urandom_range(0, 20000);
        kind = $urandom_range(0, 9);
        if (kind == 0)
            t.elapsed_ms = $urandom_range(0, 999);
        else if (kind == 1)
            t.elapsed_ms = $urandom;
        else
            t.elapsed_ms = $urandom_range(1000, 10000);
        t.user_changed = ($urandom_range(0, 4) == 0);
        return t;
    endfunction

    task automatic cfg_write(cfg_reg_t idx, logic [31:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        case (idx)
            REG_AVG_LOW:     cfg_avg_low     = val[AVG_W-1:0];
            REG_AVG_HIGH:    cfg_avg_high    = val[AVG_W-1:0];
            REG_UNBAL:       cfg_unbal       = val[15:0];
            REG_TREND_UNBAL: cfg_trend_unbal = val[7:0];
            REG_IDLE_TREND:  cfg_idle_trend  = val[7:0];
            REG_INSTANT:     cfg_instant     = val[7:0];
            REG_IRQ_RATE:    cfg_irq_rate    = val;
            REG_MODE_EN:     cfg_mode_en     = val[2:0];
            default: ;
        endcase
    endtask

    task automatic program_phase(int p);
        logic [31:0] v [8];
        if (p == 1) begin
            foreach (v[k]) v[k] = '1;
        end else if (p == 2) begin
            foreach (v[k]) v[k] = '0;
        end else begin
            v[REG_AVG_LOW]     = $urandom_range(0, 400);
            v[REG_AVG_HIGH]    = $urandom_range(200, 1200);
            v[REG_UNBAL]       = $urandom_range(100, 3000);
            v[REG_TREND_UNBAL] = $urandom_range(0, 200);
            v[REG_IDLE_TREND]  = $urandom_range(0, 40);
            v[REG_INSTANT]     = $urandom_range(40, 200);
            v[REG_IRQ_RATE]    = $urandom_range(0, 8000);
            foreach (v[k])
                if ($urandom_range(0, 7) == 0)
                    v[k] = $urandom;
            v[REG_MODE_EN] = p % 8;
        end
        foreach (v[k])
            cfg_write(cfg_reg_t'(k), v[k]);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic send_tick(gov_tick_t t, bit known, gov_result_t want);
        int          gap;
        gov_result_t r;
        gap = tx_no_gaps ? 0 : $urandom_range(0, MAX_GAP);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= pack_tick(t);
        do @(posedge aclk); while (!s_tready);
        // predictor runs on every item so its state tracks the block
        r = governor_predict(t);
        expected_results.push_back(known ? want : r);
        ticks_sent++;
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge aclk);
    endtask

    task automatic check_result(result_t got);
        gov_result_t e;
        if (expected_results.size() == 0) begin
            errors++;
            if (errors <= 10)
                $display("%0t: result item with nothing expected, mode=%0d dec=%0d",
                         $realtime, got.chosen_mode, got.decision);
        end else begin
            e = expected_results.pop_front();
            results_seen++;
            case (got.decision)
                DEC_RAISE: n_raise++;
                DEC_LOWER: n_lower++;
                default:   n_hold++;
            endcase
            if (got.apply_change === 1'b1)
                n_apply++;
            if (got.chosen_mode !== e.mode || got.apply_change !== e.apply ||
                got.decision !== e.dec || got.instant_total !== e.instant ||
                got.trend_total !== e.trend || got.balance_ratio !== e.balance ||
                got.avg_hundredths !== e.avg || got.irq_rate !== e.irq_rate) begin
                errors++;
                if (errors <= 10) begin
                    $display("%0t: mismatch on result %0d", $realtime, results_seen);
                    $display("  exp mode=%0d apply=%0d dec=%0d inst=%0d trend=%0d bal=%0d avg=%0d irq=%h",
                             e.mode, e.apply, e.dec, e.instant, e.trend, e.balance,
                             e.avg, e.irq_rate);
                    $display("  got mode=%0d apply=%0d dec=%0d inst=%0d trend=%0d bal=%0d avg=%0d irq=%h",
                             got.chosen_mode, got.apply_change, got.decision,
                             got.instant_total, got.trend_total, got.balance_ratio,
                             got.avg_hundredths, got.irq_rate);
                end
            end
        end
    endtask

    // result side: random stall after each item unless rx_no_gaps is set
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                check_result(result_t'(m_tdata));
                rx_wait = rx_no_gaps ? 0 : $urandom_range(0, MAX_GAP);
                if (rx_wait > 0)
                    m_tready <= 1'b0;
            end else if (!m_tready) begin
                rx_wait--;
                if (rx_wait <= 0)
                    m_tready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("watchdog: no item moved for %0d cycles, %0d results outstanding",
                     STALL_LIMIT, expected_results.size());
            $display("TEST FAILED");
            $finish;
        end
    end

    initial begin
        blank_res = mk_res(MODE_NONE, 0, DEC_NONE, 0, 0, 0, 0, 0);
        cfg_avg_low     = 175;
        cfg_avg_high    = 450;
        cfg_unbal       = 210;
        cfg_trend_unbal = 40;
        cfg_idle_trend  = 5;
        cfg_instant     = 85;
        cfg_irq_rate    = 1000;
        cfg_mode_en     = 0;
        for (int c = 0; c < NUM_CPUS; c++) begin
            for (int k = 0; k < HISTORY_DEPTH; k++)
                load_ring[c][k] = PCT;
            ring_slot[c] = 0;
        end
        cur_mode  = MODE_NONE;
        irq_seen  = 0;
        user_pend = 0;

        // first tick after reset: nothing online, zero rate, no mode enabled
        stim_rows.push_back('{tick: mk_tick(0, 0, 0, 0, 0, 0, 0, 0, 0, 0), known: 1'b1,
                              want: mk_res(MODE_NONE, 0, DEC_LOWER, 0, 0, 0, 0, 0)});
        // full load on both, load average and interrupt delta at their top, zero interval
        stim_rows.push_back('{tick: mk_tick(1, '1, 0, 1, '1, 0, '1, '1, 0, 0), known: 1'b1,
                              want: mk_res(MODE_NORMAL, 1, DEC_RAISE, 200, 200, 200,
                                           204799, 32'hFFFF_FFFF)});
        // both samples invalid: zero wall, idle above wall; rings untouched
        stim_rows.push_back('{tick: mk_tick(1, 0, 0, 1, 5, 6, 22'd2048, 0, 1000, 0),
                              known: 1'b1,
                              want: mk_res(MODE_NONE, 0, DEC_LOWER, 0, 200, 200, 100, 0)});
        add_row(mk_tick(1, 1000, 1000, 1, 1000, 1000, 0, 0, 999, 0));
        // fill cpu0 ring with zeros, cpu1 offline -> balance fallback once the ring reads zero
        repeat (3) add_row(mk_tick(1, 1000, 1000, 0, '1, 0, 0, 500, 2000, 0));
        add_row(mk_tick(1, 1000, 1000, 1, 1000, 0, 0, 0, 1000, 0));
        add_row(mk_tick(1, '1, 32'hFFFF_FFFE, 1, 3, 1, 22'h7FF, 0, 1000, 1));
        add_row(mk_tick(1, '1, '1, 1, 0, '1, 22'h800, 1000, 1000, 0));
        add_row(mk_tick(1, '1, '1, 1, 0, '1, 22'h800, 1001, 1000, 0));
        add_row(mk_tick(0, '1, '1, 1, 7, 0, 22'h3FF800, '1, 16'hFFFF, 0));
        add_row(mk_tick(1, 32'hAAAA_AAAA, 32'h5555_5555, 1, 32'h5555_5555, 32'h0F0F_0F0F,
                        22'h2AAAAA, 32'h5555_5555, 16'hAAAA, 1));
        add_row(mk_tick(1, 40000, 30000, 1, 40000, 10000, 22'h155555, 32'hAAAA_AAAA,
                        16'h5555, 0));

        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (stim_rows[i])
            send_tick(stim_rows[i].tick, stim_rows[i].known, stim_rows[i].want);
        drain();

        for (int p = 0; p < NUM_PHASES; p++) begin
            program_phase(p);
            phases_run++;
            tx_no_gaps = ($urandom_range(0, 3) == 0);
            rx_no_gaps = ($urandom_range(0, 3) == 0);
            repeat (PHASE_TICKS)
                send_tick(rand_tick(), 1'b0, blank_res);
            drain();
        end

        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("ran %0d ticks: directed cases, then %0d register settings", ticks_sent,
                 phases_run);
        $display("checked %0d results: %0d raise, %0d lower, %0d hold, %0d mode applies",
                 results_seen, n_raise, n_lower, n_hold, n_apply);
        if (expected_results.size() != 0)
            $display("%0d expected results never arrived", expected_results.size());
        if (errors == 0 && expected_results.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

// File: files.f
+incdir+sv
sv/lbpmg_pkg.sv
sv/lbpmg_div.sv
sv/load_based_power_mode_governor.sv
sim/load_based_power_mode_governor_test.sv
